[design/vfpm_pkg.sv]
// shared types, constants and address helper for the voxel face plane merge block
// no dependencies; imported by the top level, vfpm_ctrl and vfpm_datapath
package vfpm_pkg;

   // plane geometry
   localparam int SIDE   = 16;
   localparam int DEPTH  = SIDE * SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = 4;
   localparam int SIDE_W = IDX_W + 1;
   localparam int WORD_W = 64;

   // merge masks
   localparam logic [WORD_W-1:0] MATCH_RIGHT = 64'h0000_0000_0FFF_F0FF;
   localparam logic [WORD_W-1:0] TAKE_RIGHT  = 64'h0000_0000_0000_0F00;
   localparam logic [WORD_W-1:0] MATCH_UP    = 64'h0000_0000_0FFF_0FFF;
   localparam logic [WORD_W-1:0] TAKE_UP     = 64'h0000_0000_0000_F000;

   // request modes
   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_MERGE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // ram read address source
   typedef enum logic [1:0] {
      RD_REQ   = 2'd0,
      RD_HERE  = 2'd1,
      RD_RIGHT = 2'd2,
      RD_UP    = 2'd3
   } rd_sel_type;

   // ram write address and data source
   typedef enum logic [1:0] {
      WR_REQ   = 2'd0,
      WR_HERE  = 2'd1,
      WR_RIGHT = 2'd2,
      WR_UP    = 2'd3
   } wr_sel_type;

   // controller to datapath commands
   typedef struct packed {
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       load_req;
      logic       load_here;
      logic       add_right;
      logic       add_up;
      logic       load_rsp;
      logic       scan_init;
      logic       scan_step;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_inside;
      logic here_zero;
      logic has_right;
      logic has_up;
      logic match_right;
      logic match_up;
      logic scan_last;
   } status_type;

   // plane address of a column and row
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] col,
                                                   input logic [IDX_W-1:0] row);
      return ADDR_W'(int'(col) * SIDE + int'(row));
   endfunction

endpackage

[design/voxel_face_plane_merge.sv]
// top level of the voxel face plane merge block
// depends on vfpm_pkg, vfpm_ctrl and vfpm_datapath
//
// Holds a 16 by 16 plane of 64-bit packed face words in a ram.
// Request channel (req_): mode selects write, merge or read; column and row
// address the word; face_word is the data for a write. Response channel
// (rsp_): read_word, one response for each read request only.
// Write: the next request can follow right away.
// Read: the ram read of the request address is registered; in the wait
// state the data lands in the response register, which is valid once the
// block is idle and ready again. A read out of the plane returns 0.
// Merge: walks every word from the top row and column down, one word per
// step through the single ram read port: a zero word goes through the
// address and check states only, a nonzero one on through the right
// neighbor, upper neighbor and write back. The last two columns and rows
// skip the right or upper check. Requests are held off during the pass.
// Writes and merges are taken while a response waits; a read waits until
// the response register is free, so a stalled receiver only holds reads.
// Reset clears the controller and the response valid; the plane is not
// cleared, and words must be written before they are read or merged.
module voxel_face_plane_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [vfpm_pkg::IDX_W-1:0]    req_column,
   input  logic [vfpm_pkg::IDX_W-1:0]    req_row,
   input  logic [vfpm_pkg::WORD_W-1:0]   req_face_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vfpm_pkg::WORD_W-1:0]   rsp_read_word
);
   import vfpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   vfpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // plane storage and merge arithmetic
   vfpm_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_face_word (req_face_word),
      .rsp_read_word (rsp_read_word)
   );

endmodule

[design/vfpm_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module vfpm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/vfpm_datapath.sv]
// datapath: plane ram, scan counters, working word and response register
// depends on vfpm_pkg and vfpm_ram
module vfpm_datapath (
   input  logic                          clock,
   input  vfpm_pkg::cmd_type             cmd,
   output vfpm_pkg::status_type          status,
   input  logic [vfpm_pkg::IDX_W-1:0]    req_column,
   input  logic [vfpm_pkg::IDX_W-1:0]    req_row,
   input  logic [vfpm_pkg::WORD_W-1:0]   req_face_word,
   output logic [vfpm_pkg::WORD_W-1:0]   rsp_read_word
);
   import vfpm_pkg::*;

   localparam logic [IDX_W-1:0]  TOP_IDX   = IDX_W'(SIDE - 1);
   localparam logic [IDX_W-1:0]  MERGE_LIM = IDX_W'(SIDE - 2);
   localparam logic [SIDE_W-1:0] SIDE_VAL  = SIDE_W'(SIDE);

   logic [IDX_W-1:0]  col_ff, col_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [WORD_W-1:0] here_ff, here_in;
   logic              inside_ff, inside_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   logic [ADDR_W-1:0] addr_req, addr_here, addr_right, addr_up;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic              req_inside;

   // addresses of the request and of the scan neighborhood
   assign addr_req   = cell_addr(req_column, req_row);
   assign addr_here  = cell_addr(col_ff, row_ff);
   assign addr_right = cell_addr(col_ff + IDX_W'(1), row_ff);
   assign addr_up    = cell_addr(col_ff, row_ff + IDX_W'(1));
   assign req_inside = ({1'b0, req_column} < SIDE_VAL) && ({1'b0, req_row} < SIDE_VAL);

   // read address select
   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:   rd_addr = addr_req;
         RD_HERE:  rd_addr = addr_here;
         RD_RIGHT: rd_addr = addr_right;
         RD_UP:    rd_addr = addr_up;
         default:  rd_addr = addr_here;
      endcase
   end

   // write address and data select; merged neighbors are cleared
   always_comb begin
      unique case (cmd.wr_sel)
         WR_REQ: begin
            wr_addr = addr_req;
            wr_data = req_face_word;
         end
         WR_HERE: begin
            wr_addr = addr_here;
            wr_data = here_ff;
         end
         WR_RIGHT: begin
            wr_addr = addr_right;
            wr_data = '0;
         end
         WR_UP: begin
            wr_addr = addr_up;
            wr_data = '0;
         end
         default: begin
            wr_addr = addr_here;
            wr_data = here_ff;
         end
      endcase
   end

   vfpm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_plane (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan counters: column inner, row outer, both counting down
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.scan_init) begin
         col_in = TOP_IDX;
         row_in = TOP_IDX;
      end else if (cmd.scan_step) begin
         if (col_ff == '0) begin
            col_in = TOP_IDX;
            row_in = row_ff - IDX_W'(1);
         end else begin
            col_in = col_ff - IDX_W'(1);
         end
      end
   end

   // working word: loaded from the plane, then grows by merged neighbors
   always_comb begin
      here_in = here_ff;
      if (cmd.load_here) begin
         here_in = rd_data;
      end else if (cmd.add_right) begin
         here_in = here_ff + (rd_data & TAKE_RIGHT);
      end else if (cmd.add_up) begin
         here_in = here_ff + (rd_data & TAKE_UP);
      end
   end

   assign inside_in   = cmd.load_req ? req_inside : inside_ff;
   assign rsp_word_in = cmd.load_rsp ? (inside_ff ? rd_data : '0) : rsp_word_ff;

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      here_ff     <= here_in;
      inside_ff   <= inside_in;
      rsp_word_ff <= rsp_word_in;
   end

   // status back to the controller
   assign status.req_inside  = req_inside;
   assign status.here_zero   = (rd_data == '0);
   assign status.has_right   = (col_ff < MERGE_LIM);
   assign status.has_up      = (row_ff < MERGE_LIM);
   assign status.match_right = ((here_ff & MATCH_RIGHT) == (rd_data & MATCH_RIGHT));
   assign status.match_up    = ((here_ff & MATCH_UP) == (rd_data & MATCH_UP));
   assign status.scan_last   = (col_ff == '0) && (row_ff == '0);

   assign rsp_read_word = rsp_word_ff;

endmodule

[design/vfpm_ctrl.sv]
// controller: request decode, merge scan sequencer and response valid
// depends on vfpm_pkg
module vfpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vfpm_pkg::cmd_type      cmd,
   input  vfpm_pkg::status_type   status
);
   import vfpm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_RD_WAIT   = 7'b0000010,
      ST_ADDR      = 7'b0000100,
      ST_CHK_HERE  = 7'b0001000,
      ST_CHK_RIGHT = 7'b0010000,
      ST_CHK_UP    = 7'b0100000,
      ST_WB        = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   mode_type  mode;

   assign mode   = mode_type'(req_mode);
   assign accept = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.rd_sel    = RD_HERE;
      cmd.wr_sel    = WR_HERE;
      unique case (state_ff)
         ST_IDLE: begin
            // a read needs the response register free by the time data lands
            case (mode)
               MODE_READ: req_ready = !rsp_valid_ff || rsp_ready;
               default:   req_ready = 1'b1;
            endcase
            cmd.rd_sel   = RD_REQ;
            cmd.wr_sel   = WR_REQ;
            cmd.load_req = req_valid && req_ready;
            if (req_valid && req_ready) begin
               unique case (mode)
                  MODE_WRITE: cmd.wr_en = status.req_inside;
                  MODE_MERGE: begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_ADDR;
                  end
                  MODE_READ:  state_in = ST_RD_WAIT;
                  MODE_NONE:  state_in = ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_ADDR: begin
            cmd.rd_sel = RD_HERE;
            state_in   = ST_CHK_HERE;
         end
         ST_CHK_HERE: begin
            // zero words are skipped
            cmd.load_here = 1'b1;
            if (status.here_zero) begin
               if (status.scan_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_step = 1'b1;
                  state_in      = ST_ADDR;
               end
            end else if (status.has_right) begin
               cmd.rd_sel = RD_RIGHT;
               state_in   = ST_CHK_RIGHT;
            end else if (status.has_up) begin
               cmd.rd_sel = RD_UP;
               state_in   = ST_CHK_UP;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_CHK_RIGHT: begin
            // clear the right neighbor while fetching the upper one
            if (status.match_right) begin
               cmd.add_right = 1'b1;
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_RIGHT;
            end
            if (status.has_up) begin
               cmd.rd_sel = RD_UP;
               state_in   = ST_CHK_UP;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_CHK_UP: begin
            if (status.match_up) begin
               cmd.add_up = 1'b1;
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_UP;
            end
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_HERE;
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid: set when read data lands, cleared when taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // requests are taken only while idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request ready outside idle");

   // read data never overwrites a response still waiting
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff)
      else $error("response overwritten");

   // a merge request starts the scan at the next cycle
   a_merge_start: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_MERGE) |=> state_ff == ST_ADDR)
      else $error("merge scan did not start");

   // in the cycle after a read request is taken, the response valid is being set
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_READ) |=> rsp_valid_in)
      else $error("read response missing");

endmodule

[test/vfpm_tracker_pkg.sv]
// plane tracker for the voxel face plane merge testbench: predicts read words and checks them
// depends on vfpm_pkg for the plane geometry and the request modes
package vfpm_tracker_pkg;

   import vfpm_pkg::*;

   // compare and take masks of the greedy merge, kept apart from the design's copies
   localparam logic [WORD_W-1:0] RIGHT_KEY  = 64'h0000_0000_0FFF_F0FF;
   localparam logic [WORD_W-1:0] RIGHT_TAKE = 64'h0000_0000_0000_0F00;
   localparam logic [WORD_W-1:0] UP_KEY     = 64'h0000_0000_0FFF_0FFF;
   localparam logic [WORD_W-1:0] UP_TAKE    = 64'h0000_0000_0000_F000;
   localparam int REPORT_LIMIT = 10;

   class face_plane_tracker;
      logic [WORD_W-1:0] plane [SIDE*SIDE];
      logic [WORD_W-1:0] read_words_due [$];
      int errors;
      int responses;
      int writes;
      int merges;
      int reads;
      int ignored;

      function int slot(int column, int row);
         return column * SIDE + row;
      endfunction

      // first ten errors are printed, the rest only counted
      function void note_error(string what);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("[%0t] error: %s", $time, what);
      endfunction

      // one greedy pass, top row first and right column first, in place
      function void merge_plane();
         int here;
         int right;
         int up;
         for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
               here = slot(c, r);
               if (plane[here] == '0)
                  continue;
               // columns SIDE-2 and up never take their right neighbor
               if (c < SIDE - 2) begin
                  right = slot(c + 1, r);
                  if ((plane[here] & RIGHT_KEY) == (plane[right] & RIGHT_KEY)) begin
                     plane[here] = plane[here] + (plane[right] & RIGHT_TAKE);
                     plane[right] = '0;
                  end
               end
               // upper test sees the word after the right merge
               if (r < SIDE - 2) begin
                  up = slot(c, r + 1);
                  if ((plane[here] & UP_KEY) == (plane[up] & UP_KEY)) begin
                     plane[here] = plane[here] + (plane[up] & UP_TAKE);
                     plane[up] = '0;
                  end
               end
            end
         end
      endfunction

      // accepted request: update the plane or queue the word a read returns
      function void note_request(mode_type mode, logic [IDX_W-1:0] column,
                                 logic [IDX_W-1:0] row, logic [WORD_W-1:0] word);
         // 4-bit indexes always fall inside a 16 by 16 plane
         case (mode)
            MODE_WRITE: begin
               plane[slot(column, row)] = word;
               writes++;
            end
            MODE_MERGE: begin
               merge_plane();
               merges++;
            end
            MODE_READ: begin
               read_words_due.push_back(plane[slot(column, row)]);
               reads++;
            end
            default: ignored++;
         endcase
      endfunction

      // accepted response: compare with the oldest word due
      function void check_read_word(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         responses++;
         if (read_words_due.size() == 0) begin
            note_error($sformatf("response %0d arrived with no read due, read_word %h",
                                 responses, got));
            return;
         end
         want = read_words_due.pop_front();
         if (got !== want)
            note_error($sformatf("response %0d read_word expected %h got %h",
                                 responses, want, got));
      endfunction

      function void finish_check();
         if (read_words_due.size() != 0)
            note_error($sformatf("%0d read responses never arrived", read_words_due.size()));
      endfunction
   endclass

endpackage

[test/tb_top.sv]
// top level testbench of voxel_face_plane_merge: fills the plane, runs directed and random requests
// depends on vfpm_pkg, vfpm_tracker_pkg and the voxel_face_plane_merge rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vfpm_pkg::*;
   import vfpm_tracker_pkg::*;

   localparam int STALL_LIMIT   = 10000;
   localparam int DRAIN_CYCLES  = 1400;
   localparam int RANDOM_ITEMS  = 160;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode = MODE_NONE;
   logic [IDX_W-1:0]    req_column = '0;
   logic [IDX_W-1:0]    req_row = '0;
   logic [WORD_W-1:0]   req_face_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_read_word;

   face_plane_tracker tracker = new;

   // idle stretches for each side
   int  send_stretch = 0;
   bit  send_idle = 1'b0;
   int  take_stretch = 0;
   bit  take_idle = 1'b0;
   int  items_sent = 0;
   int  quiet_cycles = 0;

   // shared keys so that neighbors in a burst tend to match
   logic [27:0] key_pool [2];
   logic [3:0]  right_nib;
   logic [3:0]  up_nib;

   voxel_face_plane_merge u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_face_word (req_face_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_word (rsp_read_word)
   );

   always #5 clock = ~clock;

   // per-request wait, with stretches where a side never idles
   function automatic int draw_gap(inout int stretch_left, inout bit idle_on);
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(20, 80);
         idle_on = ($urandom_range(0, 3) != 0);
      end
      stretch_left--;
      return idle_on ? $urandom_range(0, 19) : 0;
   endfunction

   // face word built from the key pool, with zeros, noise and near-wrap words mixed in
   function automatic logic [WORD_W-1:0] shaped_word();
      logic [WORD_W-1:0] word;
      logic [27:0]       key;
      int                pick;
      pick = $urandom_range(0, 19);
      key = key_pool[$urandom_range(0, 1)];
      if (pick < 2)
         return '0;
      if (pick < 5)
         return {$urandom, $urandom};
      word[7:0]   = key[7:0];
      word[27:16] = key[27:16];
      word[11:8]  = ($urandom_range(0, 1) != 0) ? right_nib : 4'($urandom);
      word[15:12] = ($urandom_range(0, 1) != 0) ? up_nib : 4'($urandom);
      if (pick < 8)
         word[63:28] = '1;
      else if (pick < 13)
         word[63:28] = '0;
      else
         word[63:28] = {$urandom, 4'($urandom)};
      return word;
   endfunction

   // drive one request and hold it until the block takes it
   task automatic send_request(input mode_type mode, input logic [IDX_W-1:0] column,
                               input logic [IDX_W-1:0] row, input logic [WORD_W-1:0] word);
      int gap;
      gap = draw_gap(send_stretch, send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_column    <= column;
      req_row       <= row;
      req_face_word <= word;
      do @(posedge clock); while (!(req_valid && req_ready));
      tracker.note_request(mode, column, row, word);
      if (mode != MODE_NONE)
         items_sent++;
   endtask

   // hold the sender until every read response has come back
   task automatic wait_drained();
      if (tracker.read_words_due.size() != 0) begin
         req_valid <= 1'b0;
         while (tracker.read_words_due.size() != 0)
            @(posedge clock);
      end
   endtask

   // response side
   initial begin
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = draw_gap(take_stretch, take_idle);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         tracker.check_read_word(rsp_read_word);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no request or response for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // request side
   initial begin
      int col0;
      int row0;
      int wide;
      int tall;
      int pick;
      int base_items;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every word is written before any merge or read touches it
      for (int c = 0; c < SIDE; c++)
         for (int r = 0; r < SIDE; r++)
            send_request(MODE_WRITE, IDX_W'(c), IDX_W'(r), '0);

      // right merge that wraps, then an upper merge against the updated word
      send_request(MODE_WRITE, 4'd0, 4'd0, ALL_ONES);
      send_request(MODE_WRITE, 4'd1, 4'd0, ALL_ONES);
      send_request(MODE_WRITE, 4'd0, 4'd1, 64'h1234_5678_0000_AEFF);
      // column 14 keeps its right neighbor, column 13 takes column 14
      send_request(MODE_WRITE, 4'd14, 4'd3, 64'h0000_0000_0ABC_1234);
      send_request(MODE_WRITE, 4'd15, 4'd3, 64'h0000_0000_0ABC_1234);
      send_request(MODE_WRITE, 4'd13, 4'd3, 64'h0000_0000_0ABC_1534);
      // row 14 keeps its upper neighbor
      send_request(MODE_WRITE, 4'd5, 4'd14, 64'h0000_0000_0555_6789);
      send_request(MODE_WRITE, 4'd5, 4'd15, 64'h0000_0000_0555_6789);
      // extremes of index and data
      send_request(MODE_WRITE, 4'd7, 4'd15, ALL_ONES);
      send_request(MODE_WRITE, 4'd15, 4'd15, '0);
      // nonzero word whose key matches an empty neighbor
      send_request(MODE_WRITE, 4'd8, 4'd8, 64'h0000_0000_0000_0700);
      // unused mode changes nothing
      send_request(MODE_NONE, 4'd15, 4'd15, ALL_ONES);
      wait_drained();
      send_request(MODE_MERGE, 4'd0, 4'd0, '0);
      send_request(MODE_READ, 4'd0, 4'd0, '0);
      send_request(MODE_READ, 4'd1, 4'd0, '0);
      send_request(MODE_READ, 4'd0, 4'd1, '0);
      send_request(MODE_READ, 4'd13, 4'd3, '0);
      send_request(MODE_READ, 4'd14, 4'd3, '0);
      send_request(MODE_READ, 4'd15, 4'd3, '0);
      send_request(MODE_READ, 4'd5, 4'd14, '0);
      send_request(MODE_READ, 4'd5, 4'd15, '0);
      send_request(MODE_READ, 4'd7, 4'd15, ALL_ONES);
      send_request(MODE_READ, 4'd8, 4'd8, '0);
      send_request(MODE_READ, 4'd15, 4'd15, '0);

      // random sequences
      base_items = items_sent;
      while (items_sent - base_items < RANDOM_ITEMS) begin
         key_pool[0] = ($urandom_range(0, 3) == 0) ? '1 : 28'($urandom);
         key_pool[1] = 28'($urandom);
         right_nib   = 4'($urandom);
         up_nib      = 4'($urandom);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            // burst of related words in a small region, a merge, then read it back
            col0 = ($urandom_range(0, 1) != 0) ? $urandom_range(11, 15) : $urandom_range(0, 15);
            row0 = ($urandom_range(0, 1) != 0) ? $urandom_range(11, 15) : $urandom_range(0, 15);
            wide = $urandom_range(2, 4);
            tall = $urandom_range(2, 4);
            for (int c = col0; c < col0 + wide && c < SIDE; c++)
               for (int r = row0; r < row0 + tall && r < SIDE; r++)
                  send_request(MODE_WRITE, IDX_W'(c), IDX_W'(r), shaped_word());
            if ($urandom_range(0, 2) == 0)
               wait_drained();
            send_request(MODE_MERGE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
            for (int c = col0; c < col0 + wide && c < SIDE; c++)
               for (int r = row0; r < row0 + tall && r < SIDE; r++)
                  send_request(MODE_READ, IDX_W'(c), IDX_W'(r), {$urandom, $urandom});
         end else if (pick < 9) begin
            // scattered single requests
            repeat (8) begin
               pick = $urandom_range(0, 19);
               if (pick < 8)
                  send_request(MODE_WRITE, 4'($urandom), 4'($urandom), shaped_word());
               else if (pick < 16)
                  send_request(MODE_READ, 4'($urandom), 4'($urandom), {$urandom, $urandom});
               else if (pick < 17)
                  send_request(MODE_MERGE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
               else
                  send_request(MODE_NONE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
            end
         end else begin
            // noise: unrelated words and unused modes
            repeat (6) begin
               pick = $urandom_range(0, 2);
               if (pick == 0)
                  send_request(MODE_WRITE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
               else if (pick == 1)
                  send_request(MODE_READ, 4'($urandom), 4'($urandom), {$urandom, $urandom});
               else
                  send_request(MODE_NONE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
            end
         end
      end

      // last pass and a sweep over the whole plane
      send_request(MODE_MERGE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
      for (int c = 0; c < SIDE; c++)
         for (int r = 0; r < SIDE; r++)
            send_request(MODE_READ, IDX_W'(c), IDX_W'(r), {$urandom, $urandom});
      req_valid <= 1'b0;
      @(posedge clock);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.finish_check();
      $display("covered %0d writes, %0d merge passes, %0d reads, %0d unused-mode requests",
               tracker.writes, tracker.merges, tracker.reads, tracker.ignored);
      $display("%0d read responses compared, %0d errors", tracker.responses, tracker.errors);
      if (tracker.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
